/* rtl/core/dlns_pkg.sv */
// Shared constants, register codes and transaction types of the dual-layer scaler.
// Used by the front end, the queue, the back end and the top level.
`default_nettype none
package dlns_pkg;

   localparam int SCREEN_WIDTH   = 256;
   localparam int SCREEN_HEIGHT  = 192;
   localparam int MAX_OUTPUT_DIM = 4096;

   localparam int SCREEN_PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int STORE_DEPTH   = 2 * SCREEN_PIXELS;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   // quotient bits of the scaling divide: enough for the larger screen side
   localparam int DIV_BITS      = $clog2((SCREEN_WIDTH > SCREEN_HEIGHT) ?
                                         SCREEN_WIDTH : SCREEN_HEIGHT);
   localparam int NUM_W         = 16 + DIV_BITS;
   localparam int DIM_W         = $clog2(MAX_OUTPUT_DIM + 1) + 1;

   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   localparam logic [3:0] CSR_OUTPUT_WIDTH  = 4'd0;
   localparam logic [3:0] CSR_OUTPUT_HEIGHT = 4'd1;
   localparam logic [3:0] CSR_BACKGROUND    = 4'd2;
   localparam logic [3:0] CSR_SCREEN_ENABLE = 4'd3;
   localparam logic [3:0] CSR_TOP_ORIGIN    = 4'd4;
   localparam logic [3:0] CSR_TOP_SIZE      = 4'd5;
   localparam logic [3:0] CSR_BOTTOM_ORIGIN = 4'd6;
   localparam logic [3:0] CSR_BOTTOM_SIZE   = 4'd7;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   typedef struct packed {
      logic [12:0] raster_width;
      logic [12:0] raster_height;
      logic [31:0] backdrop_color;
      logic [1:0]  screen_enable;
      logic [31:0] top_origin;
      logic [31:0] top_size;
      logic [31:0] bottom_origin;
      logic [31:0] bottom_size;
   } cfg_type;

   // one classified transaction between front and back
   typedef struct packed {
      logic              wr;
      logic [ADDR_W-1:0] waddr;
      logic [14:0]       pix;
      logic              in_rng;
      logic              hit;
      logic              bot;
      logic [15:0]       dx;
      logic [15:0]       dy;
   } entry_type;

endpackage
`default_nettype wire

/* rtl/core/dlns_front.sv */
// Front end: accepts transactions, drops out-of-screen writes, tests range and rectangles.
// Depends on dlns_pkg.
`default_nettype none
module dlns_front import dlns_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic        req_screen_select,
   input  wire logic [15:0] req_source_index,
   input  wire logic [14:0] req_source_pixel,
   input  wire logic [11:0] req_out_x,
   input  wire logic [11:0] req_out_y,
   output logic             push,
   output entry_type        push_entry,
   input  wire logic        q_full
);

   logic      vld_ff, vld_in;
   entry_type ent_ff, ent_in;
   logic      accept;

   logic [DIM_W-1:0] eff_w, eff_h;
   logic             top_hit, bot_hit, keep;
   logic [17:0]      tdx, tdy, bdx, bdy;

   function automatic logic [17:0] offset(input logic [11:0] o, input logic [15:0] org);
      offset = {6'd0, o} - {{2{org[15]}}, org};
   endfunction

   function automatic logic covers(input logic [17:0] d, input logic [15:0] s);
      covers = !d[17] && (d < {2'b00, s});
   endfunction

   always_comb begin
      eff_w = (32'(cfg.raster_width) > MAX_OUTPUT_DIM) ? DIM_W'(MAX_OUTPUT_DIM)
                                                       : DIM_W'(cfg.raster_width);
      eff_h = (32'(cfg.raster_height) > MAX_OUTPUT_DIM) ? DIM_W'(MAX_OUTPUT_DIM)
                                                        : DIM_W'(cfg.raster_height);
      tdx = offset(req_out_x, cfg.top_origin[15:0]);
      tdy = offset(req_out_y, cfg.top_origin[31:16]);
      bdx = offset(req_out_x, cfg.bottom_origin[15:0]);
      bdy = offset(req_out_y, cfg.bottom_origin[31:16]);
      top_hit = cfg.screen_enable[0] && covers(tdx, cfg.top_size[15:0])
                && covers(tdy, cfg.top_size[31:16]);
      bot_hit = cfg.screen_enable[1] && covers(bdx, cfg.bottom_size[15:0])
                && covers(bdy, cfg.bottom_size[31:16]);

      ent_in.wr     = (req_mode == MODE_WRITE);
      ent_in.waddr  = (req_screen_select ? ADDR_W'(SCREEN_PIXELS) : ADDR_W'(0))
                      + ADDR_W'(req_source_index);
      ent_in.pix    = req_source_pixel;
      ent_in.in_rng = (DIM_W'(req_out_x) < eff_w) && (DIM_W'(req_out_y) < eff_h);
      ent_in.hit    = top_hit || bot_hit;
      ent_in.bot    = bot_hit;
      ent_in.dx     = bot_hit ? bdx[15:0] : tdx[15:0];
      ent_in.dy     = bot_hit ? bdy[15:0] : tdy[15:0];
      // drop writes past the end of a screen
      keep = (req_mode == MODE_READ) || (32'(req_source_index) < SCREEN_PIXELS);
   end

   assign req_stall  = vld_ff && q_full;
   assign accept     = req_valid && !req_stall;
   assign push       = vld_ff && !q_full;
   assign push_entry = ent_ff;

   always_comb begin
      vld_in = vld_ff;
      if (push) begin
         vld_in = 1'b0;
      end
      if (accept) begin
         vld_in = keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (accept) begin
         ent_ff <= ent_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/dlns_queue.sv */
// Short transaction queue between front and back end.
// Depends on dlns_pkg.
`default_nettype none
module dlns_queue import dlns_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           empty,
   output entry_type      head
);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wp_ff, rp_ff;
   logic [QPTR_W:0]   cnt_ff;

   assign full  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
      end
      if (push) begin
         slot_ff[wp_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("queue pop while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue count out of bounds");

endmodule
`default_nettype wire

/* rtl/core/dlns_back.sv */
// Back end: pipelined scaling divide, frame store access, pixel expansion, result register.
// Depends on dlns_pkg.
`default_nettype none
module dlns_back import dlns_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      q_empty,
   input  wire entry_type q_head,
   output logic           pop,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output logic [31:0]    rsp_pixel_value,
   output logic           rsp_in_range
);

   typedef struct packed {
      logic                vld;
      logic                wr;
      logic [ADDR_W-1:0]   waddr;
      logic [14:0]         pix;
      logic                in_rng;
      logic                hit;
      logic                bot;
      logic [15:0]         rx;
      logic [15:0]         ry;
      logic [DIV_BITS-1:0] nx;
      logic [DIV_BITS-1:0] ny;
      logic [DIV_BITS-1:0] qx;
      logic [DIV_BITS-1:0] qy;
   } div_type;

   div_type     div_ff [DIV_BITS+1];
   div_type     load;
   div_type     mem_ff;
   logic [14:0] store [STORE_DEPTH];
   logic [14:0] rdata_ff;
   logic        adv;
   logic        rsp_valid_ff;
   logic [31:0] rsp_pixel_ff;
   logic        rsp_range_ff;
   logic [NUM_W-1:0] numx, numy;
   logic [ADDR_W-1:0] raddr;

   function automatic logic [7:0] widen5(input logic [4:0] c);
      widen5 = {c, c[4:2]};
   endfunction

   // whole back end moves when the result register is free or being taken
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && !q_empty;

   always_comb begin
      numx = NUM_W'(q_head.dx) * NUM_W'(SCREEN_WIDTH);
      numy = NUM_W'(q_head.dy) * NUM_W'(SCREEN_HEIGHT);
      load.vld    = !q_empty;
      load.wr     = q_head.wr;
      load.waddr  = q_head.waddr;
      load.pix    = q_head.pix;
      load.in_rng = q_head.in_rng;
      load.hit    = q_head.hit;
      load.bot    = q_head.bot;
      load.rx     = numx[NUM_W-1:DIV_BITS];
      load.ry     = numy[NUM_W-1:DIV_BITS];
      load.nx     = numx[DIV_BITS-1:0];
      load.ny     = numy[DIV_BITS-1:0];
      load.qx     = '0;
      load.qy     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff[0].vld <= 1'b0;
      end else if (adv) begin
         div_ff[0] <= load;
      end
   end

   // one quotient bit per stage, restoring
   for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
      div_type     nxt;
      logic [16:0] tx, ty;
      logic [15:0] sx_div, sy_div;
      always_comb begin
         nxt    = div_ff[k];
         sx_div = div_ff[k].bot ? cfg.bottom_size[15:0] : cfg.top_size[15:0];
         sy_div = div_ff[k].bot ? cfg.bottom_size[31:16] : cfg.top_size[31:16];
         tx = {div_ff[k].rx, div_ff[k].nx[DIV_BITS-1]};
         ty = {div_ff[k].ry, div_ff[k].ny[DIV_BITS-1]};
         nxt.nx = DIV_BITS'({div_ff[k].nx, 1'b0});
         nxt.ny = DIV_BITS'({div_ff[k].ny, 1'b0});
         if (tx >= {1'b0, sx_div}) begin
            nxt.rx = 16'(tx - {1'b0, sx_div});
            nxt.qx = DIV_BITS'({div_ff[k].qx, 1'b1});
         end else begin
            nxt.rx = tx[15:0];
            nxt.qx = DIV_BITS'({div_ff[k].qx, 1'b0});
         end
         if (ty >= {1'b0, sy_div}) begin
            nxt.ry = 16'(ty - {1'b0, sy_div});
            nxt.qy = DIV_BITS'({div_ff[k].qy, 1'b1});
         end else begin
            nxt.ry = ty[15:0];
            nxt.qy = DIV_BITS'({div_ff[k].qy, 1'b0});
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[k+1].vld <= 1'b0;
         end else if (adv) begin
            div_ff[k+1] <= nxt;
         end
      end
   end

   assign raddr = (div_ff[DIV_BITS].bot ? ADDR_W'(SCREEN_PIXELS) : ADDR_W'(0))
                  + ADDR_W'(32'(div_ff[DIV_BITS].qy) * SCREEN_WIDTH)
                  + ADDR_W'(div_ff[DIV_BITS].qx);

   // frame store: writes and reads keep transaction order
   always_ff @(posedge clock) begin
      if (adv && div_ff[DIV_BITS].vld && div_ff[DIV_BITS].wr) begin
         store[div_ff[DIV_BITS].waddr] <= div_ff[DIV_BITS].pix;
      end
      if (adv) begin
         rdata_ff <= store[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_ff.vld <= 1'b0;
      end else if (adv) begin
         mem_ff <= div_ff[DIV_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= mem_ff.vld && !mem_ff.wr;
      end
      if (adv) begin
         rsp_range_ff <= mem_ff.in_rng;
         if (!mem_ff.in_rng) begin
            rsp_pixel_ff <= '0;
         end else if (mem_ff.hit) begin
            rsp_pixel_ff <= {8'hFF, widen5(rdata_ff[4:0]), widen5(rdata_ff[9:5]),
                             widen5(rdata_ff[14:10])};
         end else begin
            rsp_pixel_ff <= cfg.backdrop_color;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_ff;
   assign rsp_in_range    = rsp_range_ff;

endmodule
`default_nettype wire

/* rtl/core/dual_layer_nearest_scaler_compositor_top.sv */
// Top level of the dual-layer nearest-neighbor scaler: control registers and the
// front end, queue and back end. Depends on dlns_pkg, dlns_front, dlns_queue, dlns_back.
//
//   channel | direction | handshake        | carries
//   req_    | in        | valid / stall    | mode, screen, index, pixel, out_x, out_y
//   rsp_    | out       | valid / stall    | pixel_value, in_range
//   csr_    | in        | valid / ready    | register index, 32-bit data
//
// One transaction per cycle sustained while the result is not stalled; a read result passes
// the front register, queue, divider input, 8 divide stages of one quotient bit each,
// store read and result. The frame store takes one write and one read per cycle.
// Reset is synchronous; the frame store holds garbage until written.
// A stalled result holds the whole back end; the 4-entry queue absorbs requests meanwhile.
`default_nettype none
module dual_layer_nearest_scaler_compositor_top import dlns_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic        req_screen_select,
   input  wire logic [15:0] req_source_index,
   input  wire logic [14:0] req_source_pixel,
   input  wire logic [11:0] req_out_x,
   input  wire logic [11:0] req_out_y,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_pixel_value,
   output logic             rsp_in_range,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   cfg_type   cfg_ff;
   logic      push, q_full, q_empty, pop;
   entry_type push_entry, q_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.raster_width   <= 13'd256;
         cfg_ff.raster_height  <= 13'd384;
         cfg_ff.backdrop_color <= 32'hFF000000;
         cfg_ff.screen_enable  <= 2'd3;
         cfg_ff.top_origin     <= 32'd0;
         cfg_ff.top_size       <= 32'd12583168;
         cfg_ff.bottom_origin  <= 32'd12582912;
         cfg_ff.bottom_size    <= 32'd12583168;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OUTPUT_WIDTH:  cfg_ff.raster_width   <= csr_data[12:0];
            CSR_OUTPUT_HEIGHT: cfg_ff.raster_height  <= csr_data[12:0];
            CSR_BACKGROUND:    cfg_ff.backdrop_color <= csr_data;
            CSR_SCREEN_ENABLE: cfg_ff.screen_enable  <= csr_data[1:0];
            CSR_TOP_ORIGIN:    cfg_ff.top_origin     <= csr_data;
            CSR_TOP_SIZE:      cfg_ff.top_size       <= csr_data;
            CSR_BOTTOM_ORIGIN: cfg_ff.bottom_origin  <= csr_data;
            CSR_BOTTOM_SIZE:   cfg_ff.bottom_size    <= csr_data;
            default: ;
         endcase
      end
   end

   dlns_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_screen_select (req_screen_select),
      .req_source_index  (req_source_index),
      .req_source_pixel  (req_source_pixel),
      .req_out_x         (req_out_x),
      .req_out_y         (req_out_y),
      .push              (push),
      .push_entry        (push_entry),
      .q_full            (q_full)
   );

   dlns_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   dlns_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_in_range    (rsp_in_range)
   );

endmodule
`default_nettype wire

/* sim/tb_dual_layer_nearest_scaler_compositor_top.sv */
// Self-checking bench for the dual-layer nearest-neighbor scaler compositor.
// Needs dlns_pkg and dual_layer_nearest_scaler_compositor_top; predicts each read result
// from a local frame store and register copy and checks responses in order.
`default_nettype none
module tb_dual_layer_nearest_scaler_compositor_top;
   import dlns_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = 12;
   localparam int WDOG_MAX  = 20000;

   typedef struct {
      logic        mode;
      logic        scr;
      logic [15:0] idx;
      logic [14:0] pix;
      logic [11:0] ox;
      logic [11:0] oy;
   } pix_req_type;

   typedef struct {
      logic [31:0] color;
      logic        in_rng;
   } pix_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_mode = 1'b0;
   logic req_screen_select = 1'b0;
   logic [15:0] req_source_index = '0;
   logic [14:0] req_source_pixel = '0;
   logic [11:0] req_out_x = '0;
   logic [11:0] req_out_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [31:0] rsp_pixel_value;
   logic rsp_in_range;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [3:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   dual_layer_nearest_scaler_compositor_top dut (.*);

   // predictor state
   logic [14:0] shadow_store [STORE_DEPTH];
   bit          shadow_written [STORE_DEPTH];
   cfg_type     shadow_cfg;

   pix_req_type pending_reqs[$];
   pix_rsp_type expected_pixels[$];
   int  errors = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_cycles = 0;
   int  quiet_cycles = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] widen(input logic [4:0] c);
      return {c, c[4:2]};
   endfunction

   function automatic logic [31:0] expand_bgr(input logic [14:0] p);
      return {8'hFF, widen(p[4:0]), widen(p[9:5]), widen(p[14:10])};
   endfunction

   // returns 1 on hit with the store address in addr
   function automatic bit rect_lookup(input logic [31:0] org, input logic [31:0] sz,
                                      input int ox, input int oy, output int addr);
      int w, h, dx, dy, sx, sy;
      w  = sz[15:0];
      h  = sz[31:16];
      dx = ox - int'($signed(org[15:0]));
      dy = oy - int'($signed(org[31:16]));
      addr = 0;
      if (w == 0 || h == 0) return 0;
      if (dx < 0 || dy < 0 || dx >= w || dy >= h) return 0;
      sx = dx * SCREEN_WIDTH / w;
      sy = dy * SCREEN_HEIGHT / h;
      addr = sy * SCREEN_WIDTH + sx;
      return 1;
   endfunction

   function automatic void predict_pixel(input pix_req_type r);
      pix_rsp_type e;
      int w, h, a;
      if (r.mode == MODE_WRITE) begin
         if (r.idx < SCREEN_PIXELS) begin
            a = r.scr * SCREEN_PIXELS + r.idx;
            shadow_store[a] = r.pix;
            shadow_written[a] = 1;
         end
         return;
      end
      w = shadow_cfg.raster_width > MAX_OUTPUT_DIM ? MAX_OUTPUT_DIM
                                                   : shadow_cfg.raster_width;
      h = shadow_cfg.raster_height > MAX_OUTPUT_DIM ? MAX_OUTPUT_DIM
                                                    : shadow_cfg.raster_height;
      if (r.ox >= w || r.oy >= h) begin
         e.color = '0;
         e.in_rng = 0;
      end else begin
         e.color = shadow_cfg.backdrop_color;
         e.in_rng = 1;
         if (shadow_cfg.screen_enable[1] &&
             rect_lookup(shadow_cfg.bottom_origin, shadow_cfg.bottom_size, r.ox, r.oy, a))
            e.color = expand_bgr(shadow_store[SCREEN_PIXELS + a]);
         else if (shadow_cfg.screen_enable[0] &&
                  rect_lookup(shadow_cfg.top_origin, shadow_cfg.top_size, r.ox, r.oy, a))
            e.color = expand_bgr(shadow_store[a]);
      end
      expected_pixels.push_back(e);
   endfunction

   // true if a read would touch an unwritten store entry; addr gets that entry
   function automatic bit touches_unwritten(input int ox, input int oy, output int addr);
      int a;
      addr = 0;
      if (ox >= shadow_cfg.raster_width || oy >= shadow_cfg.raster_height) return 0;
      if (shadow_cfg.screen_enable[1] &&
          rect_lookup(shadow_cfg.bottom_origin, shadow_cfg.bottom_size, ox, oy, a)) begin
         addr = SCREEN_PIXELS + a;
         return !shadow_written[addr];
      end
      if (shadow_cfg.screen_enable[0] &&
          rect_lookup(shadow_cfg.top_origin, shadow_cfg.top_size, ox, oy, a)) begin
         addr = a;
         return !shadow_written[addr];
      end
      return 0;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (req_valid) predict_pixel('{req_mode, req_screen_select, req_source_index,
                                          req_source_pixel, req_out_x, req_out_y});
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               pix_req_type r;
               r = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_mode <= r.mode;
               req_screen_select <= r.scr;
               req_source_index <= r.idx;
               req_source_pixel <= r.pix;
               req_out_x <= r.ox;
               req_out_y <= r.oy;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall and monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected result: pixel_value %h in_range %b",
                      rsp_pixel_value, rsp_in_range);
               errors++;
            end else begin
               pix_rsp_type e;
               e = expected_pixels.pop_front();
               if (rsp_pixel_value !== e.color) begin
                  $error("pixel_value: expected %h actual %h", e.color, rsp_pixel_value);
                  errors++;
               end
               if (rsp_in_range !== e.in_rng) begin
                  $error("in_range: expected %b actual %b", e.in_rng, rsp_in_range);
                  errors++;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_valid
          || (pending_reqs.size() == 0 && expected_pixels.size() == 0 && !req_valid))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [3:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_OUTPUT_WIDTH:  shadow_cfg.raster_width = value[12:0];
         CSR_OUTPUT_HEIGHT: shadow_cfg.raster_height = value[12:0];
         CSR_BACKGROUND:    shadow_cfg.backdrop_color = value;
         CSR_SCREEN_ENABLE: shadow_cfg.screen_enable = value[1:0];
         CSR_TOP_ORIGIN:    shadow_cfg.top_origin = value;
         CSR_TOP_SIZE:      shadow_cfg.top_size = value;
         CSR_BOTTOM_ORIGIN: shadow_cfg.bottom_origin = value;
         CSR_BOTTOM_SIZE:   shadow_cfg.bottom_size = value;
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic void queue_write(input bit scr, input int idx, input logic [14:0] p);
      if (idx < SCREEN_PIXELS) shadow_written[(scr ? SCREEN_PIXELS : 0) + idx] = 1;
      pending_reqs.push_back('{MODE_WRITE, scr, 16'(idx), p, 12'($urandom), 12'($urandom)});
   endfunction

   // a read that would sample an unwritten entry gets a write of that entry first
   function automatic void queue_read(input int ox, input int oy);
      pix_req_type r;
      int a;
      if (touches_unwritten(ox, oy, a))
         queue_write(a >= SCREEN_PIXELS, a % SCREEN_PIXELS, 15'($urandom));
      r = '{MODE_READ, 1'($urandom), 16'($urandom), 15'($urandom), 12'(ox), 12'(oy)};
      pending_reqs.push_back(r);
   endfunction

   // random phase: mostly reads, some writes incl. out-of-range indexes
   task automatic random_items(input int n, input int wmax, input int hmax);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: queue_write($urandom_range(1), $urandom_range(65535), 15'($urandom));
            1: queue_write($urandom_range(1), $urandom_range(SCREEN_PIXELS - 1),
                           15'($urandom));
            2: queue_read($urandom_range(4095), $urandom_range(4095));
            default: queue_read($urandom_range(wmax), $urandom_range(hmax));
         endcase
      end
   endtask

   initial begin
      shadow_cfg = '{13'd256, 13'd384, 32'hFF000000, 2'd3, 32'd0, 32'd12583168,
                     32'd12582912, 32'd12583168};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, both modes, ignored write, out of range, corners
      queue_write(0, 0, 15'h7FFF);
      queue_write(1, SCREEN_PIXELS - 1, 15'h0000);
      queue_write(0, SCREEN_PIXELS, 15'h7FFF);
      queue_write(1, 65535, 15'h5555);
      queue_read(0, 0);
      queue_read(255, 191);
      queue_read(0, 192);
      queue_read(255, 383);
      queue_read(256, 0);
      queue_read(0, 384);
      queue_read(4095, 4095);
      queue_read(4095, 0);
      queue_read(100, 200);
      drain();

      // all registers, extremes: full-size raster, no screens
      write_reg(CSR_OUTPUT_WIDTH, 32'hFFFF_FFFF);
      write_reg(CSR_OUTPUT_HEIGHT, 32'd4096);
      write_reg(CSR_BACKGROUND, 32'h1234_5678);
      write_reg(CSR_SCREEN_ENABLE, 32'd0);
      write_reg(CSR_TOP_ORIGIN, 32'hFFFF_FFFF);
      write_reg(CSR_TOP_SIZE, 32'h0000_FFFF);
      write_reg(CSR_BOTTOM_ORIGIN, 32'h8000_8000);
      write_reg(CSR_BOTTOM_SIZE, 32'hFFFF_FFFF);
      write_reg(4'd15, 32'hDEAD_BEEF);
      queue_read(4095, 4095);
      queue_read(0, 0);
      queue_read(2000, 3000);
      drain();

      // negative origins, overlap, upscale and downscale
      write_reg(CSR_OUTPUT_WIDTH, 32'd640);
      write_reg(CSR_OUTPUT_HEIGHT, 32'd480);
      write_reg(CSR_BACKGROUND, 32'hFFFF_FFFF);
      write_reg(CSR_SCREEN_ENABLE, 32'd3);
      write_reg(CSR_TOP_ORIGIN, {16'hFFF0, 16'hFFE0});
      write_reg(CSR_TOP_SIZE, {16'd500, 16'd700});
      write_reg(CSR_BOTTOM_ORIGIN, {16'd100, 16'd150});
      write_reg(CSR_BOTTOM_SIZE, {16'd97, 16'd33});
      send_idle_pct = 0; recv_stall_pct = 0;
      random_items(140, 700, 520);
      drain();

      // one screen only, tiny rectangles, held-off receiver
      write_reg(CSR_OUTPUT_WIDTH, 32'd1);
      write_reg(CSR_OUTPUT_HEIGHT, 32'd8191);
      write_reg(CSR_SCREEN_ENABLE, 32'd2);
      write_reg(CSR_BOTTOM_ORIGIN, 32'd0);
      write_reg(CSR_BOTTOM_SIZE, {16'd1, 16'd1});
      hold_cycles = 300;
      send_idle_pct = 88; recv_stall_pct = 0;
      random_items(150, 3, 4095);
      drain();

      write_reg(CSR_OUTPUT_WIDTH, 32'd4096);
      write_reg(CSR_OUTPUT_HEIGHT, 32'd1);
      write_reg(CSR_SCREEN_ENABLE, 32'd1);
      write_reg(CSR_TOP_ORIGIN, {16'd0, 16'd3000});
      write_reg(CSR_TOP_SIZE, {16'd1, 16'd1096});
      send_idle_pct = 0; recv_stall_pct = 88;
      random_items(150, 4095, 2);
      drain();

      write_reg(CSR_OUTPUT_WIDTH, 32'd256);
      write_reg(CSR_OUTPUT_HEIGHT, 32'd384);
      write_reg(CSR_SCREEN_ENABLE, 32'd3);
      write_reg(CSR_TOP_ORIGIN, 32'd0);
      write_reg(CSR_TOP_SIZE, 32'd12583168);
      write_reg(CSR_BOTTOM_ORIGIN, 32'd12582912);
      write_reg(CSR_BOTTOM_SIZE, 32'd12583168);
      send_idle_pct = 25; recv_stall_pct = 25;
      random_items(160, 300, 400);
      drain();

      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire

/* dual_layer_nearest_scaler_compositor_top.f */
rtl/core/dlns_pkg.sv
rtl/core/dlns_front.sv
rtl/core/dlns_queue.sv
rtl/core/dlns_back.sv
rtl/core/dual_layer_nearest_scaler_compositor_top.sv
sim/tb_dual_layer_nearest_scaler_compositor_top.sv
